### rtl/core/vsic_pkg.sv
// Shared types, codes and constants of the start interlock controller.
package vsic_pkg;

   localparam int SampleW  = 12;
   localparam int SwitchW  = 11;
   localparam int TolW     = 12;
   localparam int PinCount = 10;

   localparam logic [TolW-1:0] KeyTolReset = 12'd100;

   // pin_levels bit positions
   localparam int PIN_KEEP  = 0;
   localparam int PIN_START = 1;
   localparam int PIN_IGN   = 2;
   localparam int PIN_READY = 3;
   localparam int PIN_NEUT  = 4;
   localparam int PIN_RIGHT = 5;
   localparam int PIN_LEFT  = 6;
   localparam int PIN_LOW   = 7;
   localparam int PIN_HIGH  = 8;
   localparam int PIN_EXTRA = 9;

   // switch_levels bit positions
   localparam int SW_LEFT    = 0;
   localparam int SW_RIGHT   = 1;
   localparam int SW_HIGH    = 2;
   localparam int SW_EXTRA   = 3;
   localparam int SW_LIGHTS  = 4;
   localparam int SW_START   = 5;
   localparam int SW_DECOMP  = 6;
   localparam int SW_ENG_ON  = 7;
   localparam int SW_NEUTRAL = 8;
   localparam int SW_STAND   = 9;
   localparam int SW_CLUTCH  = 10;

   localparam logic [1:0] MODE_CODE_KEY  = 2'd0;
   localparam logic [1:0] MODE_CODE_FAIL = 2'd1;
   localparam logic [1:0] MODE_CODE_RUN  = 2'd2;
   localparam logic [1:0] MODE_CODE_PARK = 2'd3;

   typedef enum logic [3:0] {
      MODE_KEY  = 4'b0001,
      MODE_FAIL = 4'b0010,
      MODE_RUN  = 4'b0100,
      MODE_PARK = 4'b1000
   } mode_type;

   typedef enum logic [3:0] {
      ENG_STOP = 4'b0001,
      ENG_WAIT = 4'b0010,
      ENG_ELEC = 4'b0100,
      ENG_RUN  = 4'b1000
   } engine_type;

   typedef struct packed {
      logic               operation;
      logic [SampleW-1:0] sample_x1;
      logic [SampleW-1:0] sample_x2;
      logic [SampleW-1:0] sample_y1;
      logic [SampleW-1:0] sample_y2;
      logic               samples_valid;
      logic               fault;
      logic [SwitchW-1:0] switch_levels;
   } req_payload_type;

   typedef struct packed {
      logic       keepalive_pin;
      logic       starter_pin;
      logic       ignition_enable_pin;
      logic       ready_lamp_pin;
      logic       neutral_lamp_pin;
      logic       right_arrow_pin;
      logic       left_arrow_pin;
      logic       low_beam_pin;
      logic       high_beam_pin;
      logic       extra_light_pin;
      logic [1:0] mode;
   } rsp_payload_type;

   // control fields of a registered beat, samples travel separately
   typedef struct packed {
      logic               operation;
      logic               samples_valid;
      logic               fault;
      logic [SwitchW-1:0] switch_levels;
   } item_ctl_type;

   typedef struct packed {
      mode_type            top_mode;
      engine_type          engine_state;
      logic                decomp_latched;
      logic                flash_phase;
      logic                failure_toggle;
      logic [PinCount-1:0] pins;
   } ctl_state_type;

   function automatic logic [1:0] mode_code(mode_type m);
      logic [1:0] code;
      case (m)
         MODE_KEY:  code = MODE_CODE_KEY;
         MODE_FAIL: code = MODE_CODE_FAIL;
         MODE_RUN:  code = MODE_CODE_RUN;
         MODE_PARK: code = MODE_CODE_PARK;
         default:   code = MODE_CODE_KEY;
      endcase
      return code;
   endfunction

endpackage

### rtl/core/vsic_req_if.sv
// Request channel: valid/ready handshake with one control or tick beat.
interface vsic_req_if
   import vsic_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/vsic_rsp_if.sv
// Response channel: valid/ready handshake carrying pin levels and mode.
interface vsic_rsp_if
   import vsic_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/vsic_step.sv
// Next-state logic: applies one tick or control pass to the controller state.
module vsic_step
   import vsic_pkg::*;
#(
   parameter int KEY_BITS = 12
) (
   input  item_ctl_type        ctl,
   input  logic [KEY_BITS-1:0] key_x1,
   input  logic [KEY_BITS-1:0] key_x2,
   input  logic [KEY_BITS-1:0] key_y1,
   input  logic [KEY_BITS-1:0] key_y2,
   input  logic [TolW-1:0]     tolerance,
   input  ctl_state_type       state_in,
   output ctl_state_type       state_out
);

   logic [KEY_BITS-1:0] diff_x;
   logic [KEY_BITS-1:0] diff_y;
   logic                key_ok;
   logic [SwitchW-1:0]  sw;

   assign diff_x = (key_x1 > key_y1) ? key_x1 - key_y1 : key_y1 - key_x1;
   assign diff_y = (key_x2 > key_y2) ? key_x2 - key_y2 : key_y2 - key_x2;
   assign key_ok = ctl.samples_valid &&
                   (TolW'(diff_x) < tolerance) && (TolW'(diff_y) < tolerance);
   assign sw = ctl.switch_levels;

   always_comb begin
      state_out = state_in;
      if (ctl.operation) begin
         state_out.flash_phase = ~state_in.flash_phase;
      end else if (ctl.fault && (state_in.top_mode != MODE_FAIL)) begin
         state_out.top_mode = MODE_FAIL;
      end else begin
         case (state_in.top_mode)
            MODE_FAIL: begin
               state_out.failure_toggle = ~state_in.failure_toggle;
               state_out.pins[PIN_LEFT]  = ~state_in.failure_toggle;
               state_out.pins[PIN_RIGHT] = ~state_in.failure_toggle;
               state_out.pins[PIN_NEUT]  = ~state_in.failure_toggle;
               state_out.pins[PIN_START] = 1'b0;
               state_out.pins[PIN_IGN]   = 1'b0;
               state_out.pins[PIN_READY] = 1'b0;
            end
            MODE_KEY: begin
               if (key_ok) begin
                  state_out.pins[PIN_KEEP] = 1'b1;
                  state_out.top_mode = MODE_RUN;
               end else begin
                  state_out.pins[PIN_RIGHT] = 1'b0;
                  state_out.pins[PIN_LEFT]  = 1'b0;
                  state_out.pins[PIN_LOW]   = 1'b0;
                  state_out.pins[PIN_HIGH]  = 1'b0;
                  state_out.pins[PIN_EXTRA] = 1'b0;
               end
            end
            MODE_RUN: begin
               state_out.pins[PIN_LOW]   = sw[SW_LIGHTS];
               state_out.pins[PIN_HIGH]  = sw[SW_LIGHTS] & sw[SW_HIGH];
               state_out.pins[PIN_EXTRA] = sw[SW_LIGHTS] & sw[SW_EXTRA];

               // left wins over right
               state_out.pins[PIN_LEFT]  = sw[SW_LEFT] & state_in.flash_phase;
               state_out.pins[PIN_RIGHT] = ~sw[SW_LEFT] & sw[SW_RIGHT] &
                                           state_in.flash_phase;

               if (sw[SW_DECOMP]) begin
                  state_out.decomp_latched = 1'b1;
               end

               if (!sw[SW_NEUTRAL] && !sw[SW_STAND] &&
                   (state_in.engine_state != ENG_STOP)) begin
                  state_out.engine_state = ENG_STOP;
                  state_out.pins[PIN_IGN] = 1'b0;
               end
               if (!sw[SW_ENG_ON]) begin
                  state_out.engine_state = ENG_STOP;
                  state_out.pins[PIN_IGN] = 1'b0;
               end
               if (!sw[SW_START]) begin
                  state_out.pins[PIN_START] = 1'b0;
               end

               case (state_out.engine_state)
                  ENG_STOP: begin
                     state_out.pins[PIN_IGN]   = 1'b0;
                     state_out.pins[PIN_READY] = 1'b0;
                     state_out.pins[PIN_START] = 1'b0;
                     if (!sw[SW_ENG_ON] && sw[SW_HIGH] && !sw[SW_STAND]) begin
                        state_out.top_mode = MODE_PARK;
                     end else if ((sw[SW_NEUTRAL] || sw[SW_CLUTCH]) &&
                                  state_out.decomp_latched && sw[SW_ENG_ON]) begin
                        state_out.engine_state = ENG_WAIT;
                     end
                  end
                  ENG_WAIT: begin
                     state_out.pins[PIN_IGN]   = 1'b1;
                     state_out.pins[PIN_READY] = 1'b1;
                     if (!sw[SW_NEUTRAL] && !sw[SW_CLUTCH]) begin
                        state_out.decomp_latched  = 1'b0;
                        state_out.engine_state    = ENG_RUN;
                        state_out.pins[PIN_READY] = 1'b0;
                     end else if (sw[SW_START]) begin
                        state_out.pins[PIN_READY] = 1'b0;
                        state_out.decomp_latched  = 1'b0;
                        state_out.engine_state    = ENG_ELEC;
                     end
                  end
                  ENG_ELEC: begin
                     state_out.pins[PIN_START] = sw[SW_START];
                     if (!sw[SW_START]) begin
                        state_out.engine_state = ENG_RUN;
                     end
                  end
                  ENG_RUN: begin
                     state_out.pins[PIN_READY] = 1'b0;
                     if (sw[SW_DECOMP]) begin
                        state_out.engine_state   = ENG_STOP;
                        state_out.pins[PIN_IGN]  = 1'b0;
                        state_out.decomp_latched = 1'b0;
                     end
                  end
                  default: begin
                     state_out.engine_state = ENG_STOP;
                  end
               endcase
            end
            MODE_PARK: begin
               state_out.pins[PIN_LEFT]  = state_in.flash_phase;
               state_out.pins[PIN_RIGHT] = state_in.flash_phase;
               state_out.pins[PIN_LOW]   = 1'b1;
            end
            default: begin
               state_out.top_mode = MODE_FAIL;
            end
         endcase
      end
   end

endmodule

### rtl/core/vehicle_start_interlock_controller.sv
// Top level of the motorbike ignition and lighting interlock controller.
// Accepts one beat per clock (a blink tick or a control pass) and returns one
// response beat per request carrying all ten pin levels and the mode after
// that beat. A request lands in the input register; when it advances, the
// controller state is updated from it and the response register loads at the
// same edge. Throughput is one beat per cycle while responses are taken. A
// stalled response holds the input stage, and the request side keeps taking a
// beat whenever the input stage will drain at that edge. Key samples are
// compared on their low min(SAMPLE_BITS, 12) bits. key_tolerance resets to
// 100 and is written through csr_write_enable/csr_write_data; the user must
// write it only while no beat is in flight; the block does not enforce it.
module vehicle_start_interlock_controller
   import vsic_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic            clock,
   input  logic            reset,
   vsic_req_if.sink        req_bus,
   vsic_rsp_if.source      rsp_bus,
   input  logic            csr_write_enable,
   input  logic [TolW-1:0] csr_write_data
);

   localparam int KeyBits = (SAMPLE_BITS < SampleW) ? SAMPLE_BITS : SampleW;

   logic [TolW-1:0]    tol_ff;
   logic               s1_valid_ff;
   logic               s1_valid_in;
   item_ctl_type       s1_ctl_ff;
   logic [KeyBits-1:0] s1_x1_ff;
   logic [KeyBits-1:0] s1_x2_ff;
   logic [KeyBits-1:0] s1_y1_ff;
   logic [KeyBits-1:0] s1_y2_ff;
   ctl_state_type      state_ff;
   ctl_state_type      state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_payload_type    rsp_ff;
   rsp_payload_type    rsp_in;
   logic               req_take;
   logic               advance;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !s1_valid_ff || advance;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   vsic_step #(
      .KEY_BITS (KeyBits)
   ) u_step (
      .ctl       (s1_ctl_ff),
      .key_x1    (s1_x1_ff),
      .key_x2    (s1_x2_ff),
      .key_y1    (s1_y1_ff),
      .key_y2    (s1_y2_ff),
      .tolerance (tol_ff),
      .state_in  (state_ff),
      .state_out (state_in)
   );

   always_comb begin
      rsp_in.keepalive_pin       = state_in.pins[PIN_KEEP];
      rsp_in.starter_pin         = state_in.pins[PIN_START];
      rsp_in.ignition_enable_pin = state_in.pins[PIN_IGN];
      rsp_in.ready_lamp_pin      = state_in.pins[PIN_READY];
      rsp_in.neutral_lamp_pin    = state_in.pins[PIN_NEUT];
      rsp_in.right_arrow_pin     = state_in.pins[PIN_RIGHT];
      rsp_in.left_arrow_pin      = state_in.pins[PIN_LEFT];
      rsp_in.low_beam_pin        = state_in.pins[PIN_LOW];
      rsp_in.high_beam_pin       = state_in.pins[PIN_HIGH];
      rsp_in.extra_light_pin     = state_in.pins[PIN_EXTRA];
      rsp_in.mode                = mode_code(state_in.top_mode);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= KeyTolReset;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.top_mode       <= MODE_KEY;
         state_ff.engine_state   <= ENG_STOP;
         state_ff.decomp_latched <= 1'b0;
         state_ff.flash_phase    <= 1'b0;
         state_ff.failure_toggle <= 1'b0;
         state_ff.pins           <= '0;
      end else begin
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ctl_ff.operation     <= req_bus.payload.operation;
         s1_ctl_ff.samples_valid <= req_bus.payload.samples_valid;
         s1_ctl_ff.fault         <= req_bus.payload.fault;
         s1_ctl_ff.switch_levels <= req_bus.payload.switch_levels;
         s1_x1_ff <= req_bus.payload.sample_x1[KeyBits-1:0];
         s1_x2_ff <= req_bus.payload.sample_x2[KeyBits-1:0];
         s1_y1_ff <= req_bus.payload.sample_y1[KeyBits-1:0];
         s1_y2_ff <= req_bus.payload.sample_y2[KeyBits-1:0];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### tb/vehicle_start_interlock_controller_test.sv
// Self-checking regression of the start interlock controller against a beat-level predictor.
module vehicle_start_interlock_controller_test;
   import vsic_pkg::*;

   localparam int LongHold = 300;

   localparam logic [SwitchW-1:0] B_LEFT    = 11'd1 << SW_LEFT;
   localparam logic [SwitchW-1:0] B_RIGHT   = 11'd1 << SW_RIGHT;
   localparam logic [SwitchW-1:0] B_HIGH    = 11'd1 << SW_HIGH;
   localparam logic [SwitchW-1:0] B_EXTRA   = 11'd1 << SW_EXTRA;
   localparam logic [SwitchW-1:0] B_LIGHTS  = 11'd1 << SW_LIGHTS;
   localparam logic [SwitchW-1:0] B_START   = 11'd1 << SW_START;
   localparam logic [SwitchW-1:0] B_DECOMP  = 11'd1 << SW_DECOMP;
   localparam logic [SwitchW-1:0] B_ENG_ON  = 11'd1 << SW_ENG_ON;
   localparam logic [SwitchW-1:0] B_NEUTRAL = 11'd1 << SW_NEUTRAL;
   localparam logic [SwitchW-1:0] B_STAND   = 11'd1 << SW_STAND;
   localparam logic [SwitchW-1:0] B_CLUTCH  = 11'd1 << SW_CLUTCH;

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_write_enable;
   logic [TolW-1:0] csr_write_data;

   vsic_req_if req_bus ();
   vsic_rsp_if rsp_bus ();

   vehicle_start_interlock_controller u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // predicted controller state
   logic [TolW-1:0]     tol_now     = KeyTolReset;
   mode_type            ctl_mode    = MODE_KEY;
   engine_type          eng_state   = ENG_STOP;
   logic                decomp_held = 1'b0;
   logic                flasher     = 1'b0;
   logic                fail_blink  = 1'b0;
   logic [PinCount-1:0] pin_state   = '0;

   req_payload_type pending_beats[$];
   rsp_payload_type expected_pins[$];

   int beats_queued = 0;
   int beats_accepted = 0;
   int results_seen = 0;
   int mismatches = 0;
   int send_gap = 0;
   int send_calm = 0;
   int rsp_stall_left = 0;
   int rsp_calm = 0;
   int long_holds_wanted = 0;
   int long_holds_done = 0;
   int ticks = 0;
   int key_passes = 0;
   int run_passes = 0;
   int park_passes = 0;
   int fail_passes = 0;
   int cranks = 0;
   int tol_writes = 0;

   // Applies one beat to the predicted state and returns the pins and mode after it.
   function automatic rsp_payload_type advance_controller(req_payload_type beat);
      logic [SwitchW-1:0] sw;
      int                 d1;
      int                 d2;
      rsp_payload_type    res;
      sw = beat.switch_levels;
      if (beat.operation) begin
         ticks++;
         flasher = ~flasher;
      end else if (beat.fault && ctl_mode != MODE_FAIL) begin
         ctl_mode = MODE_FAIL;
      end else begin
         case (ctl_mode)
            MODE_FAIL: begin
               fail_passes++;
               fail_blink = ~fail_blink;
               pin_state[PIN_LEFT]  = fail_blink;
               pin_state[PIN_RIGHT] = fail_blink;
               pin_state[PIN_NEUT]  = fail_blink;
               pin_state[PIN_START] = 1'b0;
               pin_state[PIN_IGN]   = 1'b0;
               pin_state[PIN_READY] = 1'b0;
            end
            MODE_KEY: begin
               key_passes++;
               // samples are full width at SAMPLE_BITS = 12, so no masking
               d1 = int'(beat.sample_x1) - int'(beat.sample_y1);
               d2 = int'(beat.sample_x2) - int'(beat.sample_y2);
               if (d1 < 0) d1 = -d1;
               if (d2 < 0) d2 = -d2;
               if (beat.samples_valid && d1 < int'(tol_now) && d2 < int'(tol_now)) begin
                  pin_state[PIN_KEEP] = 1'b1;
                  ctl_mode = MODE_RUN;
               end else begin
                  pin_state[PIN_RIGHT] = 1'b0;
                  pin_state[PIN_LEFT]  = 1'b0;
                  pin_state[PIN_LOW]   = 1'b0;
                  pin_state[PIN_HIGH]  = 1'b0;
                  pin_state[PIN_EXTRA] = 1'b0;
               end
            end
            MODE_RUN: begin
               run_passes++;
               if (sw[SW_LIGHTS]) begin
                  pin_state[PIN_LOW]   = 1'b1;
                  pin_state[PIN_HIGH]  = sw[SW_HIGH];
                  pin_state[PIN_EXTRA] = sw[SW_EXTRA];
               end else begin
                  pin_state[PIN_LOW]   = 1'b0;
                  pin_state[PIN_HIGH]  = 1'b0;
                  pin_state[PIN_EXTRA] = 1'b0;
               end
               if (sw[SW_LEFT]) begin
                  pin_state[PIN_LEFT]  = flasher;
                  pin_state[PIN_RIGHT] = 1'b0;
               end else if (sw[SW_RIGHT]) begin
                  pin_state[PIN_RIGHT] = flasher;
                  pin_state[PIN_LEFT]  = 1'b0;
               end else begin
                  pin_state[PIN_RIGHT] = 1'b0;
                  pin_state[PIN_LEFT]  = 1'b0;
               end
               if (sw[SW_DECOMP]) decomp_held = 1'b1;
               // in gear with the stand down, or engine switch off: engine stops
               if ((!sw[SW_NEUTRAL] && !sw[SW_STAND] && eng_state != ENG_STOP) ||
                   !sw[SW_ENG_ON]) begin
                  eng_state = ENG_STOP;
                  pin_state[PIN_IGN] = 1'b0;
               end
               if (!sw[SW_START]) pin_state[PIN_START] = 1'b0;
               case (eng_state)
                  ENG_STOP: begin
                     pin_state[PIN_IGN]   = 1'b0;
                     pin_state[PIN_READY] = 1'b0;
                     pin_state[PIN_START] = 1'b0;
                     if (!sw[SW_ENG_ON] && sw[SW_HIGH] && !sw[SW_STAND])
                        ctl_mode = MODE_PARK;
                     else if ((sw[SW_NEUTRAL] || sw[SW_CLUTCH]) && decomp_held && sw[SW_ENG_ON])
                        eng_state = ENG_WAIT;
                  end
                  ENG_WAIT: begin
                     pin_state[PIN_IGN]   = 1'b1;
                     pin_state[PIN_READY] = 1'b1;
                     if (!sw[SW_NEUTRAL] && !sw[SW_CLUTCH]) begin
                        decomp_held = 1'b0;
                        eng_state = ENG_RUN;
                        pin_state[PIN_READY] = 1'b0;
                     end else if (sw[SW_START]) begin
                        cranks++;
                        pin_state[PIN_READY] = 1'b0;
                        decomp_held = 1'b0;
                        eng_state = ENG_ELEC;
                     end
                  end
                  ENG_ELEC: begin
                     pin_state[PIN_START] = sw[SW_START];
                     if (!sw[SW_START]) eng_state = ENG_RUN;
                  end
                  default: begin
                     pin_state[PIN_READY] = 1'b0;
                     if (sw[SW_DECOMP]) begin
                        eng_state = ENG_STOP;
                        pin_state[PIN_IGN] = 1'b0;
                        decomp_held = 1'b0;
                     end
                  end
               endcase
            end
            default: begin
               park_passes++;
               pin_state[PIN_LEFT]  = flasher;
               pin_state[PIN_RIGHT] = flasher;
               pin_state[PIN_LOW]   = 1'b1;
            end
         endcase
      end
      res.keepalive_pin       = pin_state[PIN_KEEP];
      res.starter_pin         = pin_state[PIN_START];
      res.ignition_enable_pin = pin_state[PIN_IGN];
      res.ready_lamp_pin      = pin_state[PIN_READY];
      res.neutral_lamp_pin    = pin_state[PIN_NEUT];
      res.right_arrow_pin     = pin_state[PIN_RIGHT];
      res.left_arrow_pin      = pin_state[PIN_LEFT];
      res.low_beam_pin        = pin_state[PIN_LOW];
      res.high_beam_pin       = pin_state[PIN_HIGH];
      res.extra_light_pin     = pin_state[PIN_EXTRA];
      case (ctl_mode)
         MODE_FAIL: res.mode = MODE_CODE_FAIL;
         MODE_RUN:  res.mode = MODE_CODE_RUN;
         MODE_PARK: res.mode = MODE_CODE_PARK;
         default:   res.mode = MODE_CODE_KEY;
      endcase
      return res;
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_payload_type random_beat();
      req_payload_type b;
      b = $bits(req_payload_type)'({$urandom(), $urandom()});
      return b;
   endfunction

   // engine off with high beam and stand down would park for good
   function automatic logic [SwitchW-1:0] no_parking(logic [SwitchW-1:0] sw);
      if (!sw[SW_ENG_ON] && sw[SW_HIGH]) sw[SW_STAND] = 1'b1;
      return sw;
   endfunction

   function automatic logic [SwitchW-1:0] sw_with(input int eng_on, start, decomp,
                                                   neutral, stand, clutch);
      logic [SwitchW-1:0] sw;
      sw = SwitchW'($urandom_range(0, 2047));
      sw[SW_ENG_ON]  = eng_on[0];
      sw[SW_START]   = start[0];
      sw[SW_DECOMP]  = decomp[0];
      sw[SW_NEUTRAL] = neutral[0];
      sw[SW_STAND]   = stand[0];
      sw[SW_CLUTCH]  = clutch[0];
      return no_parking(sw);
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("ERROR result %0d: %s", results_seen, what);
   endtask

   task automatic check_field(string name, logic [1:0] got, logic [1:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   task automatic check_pin(string name, logic got, logic want);
      if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   task automatic push_beat(req_payload_type b);
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   task automatic push_tick();
      req_payload_type b;
      b = random_beat();
      b.operation = 1'b1;
      push_beat(b);
   endtask

   task automatic push_pass(logic [SwitchW-1:0] sw);
      req_payload_type b;
      b = random_beat();
      b.operation = 1'b0;
      b.fault = 1'b0;
      b.switch_levels = sw;
      push_beat(b);
   endtask

   task automatic push_run_pass(logic [SwitchW-1:0] sw);
      if ($urandom_range(0, 5) == 0) push_tick();
      push_pass(sw);
   endtask

   task automatic push_key(int x1, int y1, int x2, int y2, logic ok);
      req_payload_type b;
      b = random_beat();
      b.operation = 1'b0;
      b.fault = 1'b0;
      b.sample_x1 = SampleW'(x1);
      b.sample_y1 = SampleW'(y1);
      b.sample_x2 = SampleW'(x2);
      b.sample_y2 = SampleW'(y2);
      b.samples_valid = ok;
      push_beat(b);
   endtask

   // a sample pair at least tol apart
   task automatic far_pair(input int tol, output int a, output int b);
      int lo;
      int hi;
      lo = $urandom_range(0, 4095 - tol);
      hi = lo + $urandom_range(tol, 4095 - lo);
      if ($urandom_range(0, 1)) begin
         a = lo;
         b = hi;
      end else begin
         a = hi;
         b = lo;
      end
   endtask

   // key passes that must be rejected at the current tolerance, mixed with ticks
   task automatic push_key_mix(int count);
      int first;
      int x1, y1, x2, y2;
      int sel;
      logic ok;
      first = beats_queued;
      while (beats_queued - first < count) begin
         if ($urandom_range(0, 5) == 0) push_tick();
         x1 = $urandom_range(0, 4095);
         y1 = $urandom_range(0, 4095);
         x2 = $urandom_range(0, 4095);
         y2 = $urandom_range(0, 4095);
         ok = 1'($urandom_range(0, 1));
         sel = $urandom_range(0, 3);
         if (tol_now != 0) begin
            if (sel == 0) begin
               ok = 1'b0;
            end else begin
               if (sel != 2) far_pair(int'(tol_now), x1, y1);
               if (sel != 1) far_pair(int'(tol_now), x2, y2);
            end
         end
         push_key(x1, y1, x2, y2, ok);
      end
   endtask

   // arm, start (kick or electric), ride, then shut down one of three ways
   task automatic push_start_sequence();
      int n;
      n = $urandom_range(0, 1);
      push_run_pass(sw_with(1, 0, 1, n, $urandom_range(0, 1), n ? $urandom_range(0, 1) : 1));
      if ($urandom_range(0, 2) == 0) begin
         push_run_pass(sw_with(1, 0, 0, 0, 1, 0));
      end else begin
         repeat ($urandom_range(1, 4))
            push_run_pass(sw_with(1, 1, 0, 1, $urandom_range(0, 1), $urandom_range(0, 1)));
         push_run_pass(sw_with(1, 0, 0, 1, $urandom_range(0, 1), $urandom_range(0, 1)));
      end
      repeat ($urandom_range(1, 5))
         push_run_pass(sw_with(1, 0, 0, $urandom_range(0, 1), 1, $urandom_range(0, 1)));
      case ($urandom_range(0, 2))
         0: push_run_pass(sw_with(1, 0, 1, $urandom_range(0, 1), $urandom_range(0, 1),
                                  $urandom_range(0, 1)));
         1: push_run_pass(sw_with(0, $urandom_range(0, 1), $urandom_range(0, 1),
                                  $urandom_range(0, 1), $urandom_range(0, 1),
                                  $urandom_range(0, 1)));
         default: push_run_pass(sw_with(1, $urandom_range(0, 1), 0, 0, 0, $urandom_range(0, 1)));
      endcase
   endtask

   task automatic push_run_mix(int count);
      int first;
      first = beats_queued;
      while (beats_queued - first < count) begin
         if ($urandom_range(0, 9) < 6)
            push_start_sequence();
         else
            repeat ($urandom_range(1, 4))
               push_run_pass(no_parking(SwitchW'($urandom_range(0, 2047))));
      end
   endtask

   task automatic wait_idle();
      while (beats_accepted != beats_queued || expected_pins.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_tolerance(int v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= TolW'(v);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tol_now = TolW'(v);
      tol_writes++;
      repeat (2) @(posedge clock);
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_pins.push_back(advance_controller(req_bus.payload));
            beats_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               req_bus.payload <= pending_beats.pop_front();
               req_bus.valid <= 1'b1;
               if (send_calm > 0) begin
                  send_calm--;
                  send_gap = 0;
               end else begin
                  send_gap = idle_length();
                  if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_pins.size() == 0) begin
               report_mismatch("result beat with nothing outstanding");
            end else begin
               want = expected_pins.pop_front();
               check_pin("keepalive_pin", rsp_bus.payload.keepalive_pin, want.keepalive_pin);
               check_pin("starter_pin", rsp_bus.payload.starter_pin, want.starter_pin);
               check_pin("ignition_enable_pin", rsp_bus.payload.ignition_enable_pin,
                         want.ignition_enable_pin);
               check_pin("ready_lamp_pin", rsp_bus.payload.ready_lamp_pin, want.ready_lamp_pin);
               check_pin("neutral_lamp_pin", rsp_bus.payload.neutral_lamp_pin,
                         want.neutral_lamp_pin);
               check_pin("right_arrow_pin", rsp_bus.payload.right_arrow_pin,
                         want.right_arrow_pin);
               check_pin("left_arrow_pin", rsp_bus.payload.left_arrow_pin, want.left_arrow_pin);
               check_pin("low_beam_pin", rsp_bus.payload.low_beam_pin, want.low_beam_pin);
               check_pin("high_beam_pin", rsp_bus.payload.high_beam_pin, want.high_beam_pin);
               check_pin("extra_light_pin", rsp_bus.payload.extra_light_pin,
                         want.extra_light_pin);
               check_field("mode", rsp_bus.payload.mode, want.mode);
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (long_holds_done < long_holds_wanted) begin
            // long hold-off so the block backs up and stalls its input
            long_holds_done++;
            rsp_stall_left = LongHold - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_calm > 0)
               rsp_calm--;
            else if ($urandom_range(0, 3) == 0)
               rsp_stall_left = idle_length();
            else if ($urandom_range(0, 49) == 0)
               rsp_calm = $urandom_range(20, 80);
         end
      end
   end

   initial begin : stimulus
      req_payload_type b;
      int guard;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // key check at the reset tolerance: tick with every field set, then rejects
      b = '1;
      push_beat(b);
      push_key(0, 0, 0, 0, 1'b0);
      push_key(100, 0, 4095, 4095, 1'b1);
      push_key(0, 4095, 5, 5, 1'b1);
      push_key(2048, 2048, 4095, 3995, 1'b1);
      push_key(1234, 1234, 77, 77, 1'b0);
      wait_idle();

      // zero tolerance never accepts, so anything goes
      write_tolerance(0);
      push_key_mix(40);
      wait_idle();
      write_tolerance(4095);
      push_key_mix(40);
      wait_idle();
      write_tolerance(1);
      push_key_mix(30);
      wait_idle();
      repeat (2) begin
         write_tolerance($urandom_range(2, 4094));
         push_key_mix(40);
         wait_idle();
      end

      // accept with both pairs one below the tolerance
      write_tolerance(int'(KeyTolReset));
      push_key(4095, 3996, 0, 99, 1'b1);
      push_pass('0);
      push_tick();
      push_pass(B_LEFT | B_LIGHTS | B_HIGH | B_EXTRA | B_STAND);
      push_pass(B_RIGHT | B_LIGHTS | B_EXTRA);
      push_pass(B_LEFT | B_RIGHT | B_LIGHTS);
      push_pass(B_ENG_ON | B_DECOMP | B_NEUTRAL);
      push_pass(B_ENG_ON | B_NEUTRAL | B_START);
      push_pass(B_ENG_ON | B_NEUTRAL | B_START);
      push_pass(B_ENG_ON | B_NEUTRAL);
      push_pass(B_ENG_ON | B_STAND | B_LIGHTS | B_HIGH);
      push_pass(B_ENG_ON | B_STAND | B_DECOMP);
      push_pass(B_ENG_ON | B_CLUTCH | B_DECOMP);
      push_pass(B_ENG_ON | B_STAND);
      push_pass(B_ENG_ON);

      push_run_mix(170);
      long_holds_wanted++;
      wait_idle();
      write_tolerance($urandom_range(0, 4095));
      push_run_mix(85);
      // sender pauses until everything is back
      wait_idle();
      push_run_mix(85);
      wait_idle();
      write_tolerance($urandom_range(0, 4095));
      push_run_mix(170);
      wait_idle();

      // parking: engine off, high beam, stand down
      push_pass(B_HIGH);
      push_tick();
      push_pass('1);
      repeat (50) begin
         b = random_beat();
         b.fault = 1'b0;
         b.operation = ($urandom_range(0, 3) == 0);
         push_beat(b);
      end
      long_holds_wanted++;
      wait_idle();

      // failure from parking; fault has no further effect there
      b = random_beat();
      b.operation = 1'b0;
      b.fault = 1'b1;
      push_beat(b);
      repeat (50) begin
         b = random_beat();
         b.operation = ($urandom_range(0, 3) == 0);
         push_beat(b);
      end

      guard = 0;
      while ((beats_accepted != beats_queued || expected_pins.size() != 0) && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (beats_accepted != beats_queued || expected_pins.size() != 0)
         report_mismatch($sformatf("%0d results never arrived",
                                   expected_pins.size() + beats_queued - beats_accepted));
      $display("covered %0d beats: %0d blink ticks, key/run/parking/failure passes %0d/%0d/%0d/%0d",
               results_seen, ticks, key_passes, run_passes, park_passes, fail_passes);
      $display("%0d tolerance writes, %0d starter cranks, %0d mismatches",
               tol_writes, cranks, mismatches);
      if (mismatches == 0)
         $display("vehicle_start_interlock_controller regression: pass");
      else
         $display("vehicle_start_interlock_controller regression: fail");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("vehicle_start_interlock_controller regression: fail");
      $finish;
   end

endmodule
